// ===== sv/lut_piecewise_linear_interp_core_macros.svh =====
// Assertion macros for the interpolation core's RTL files; lpi_ctrl uses them.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef LUT_PIECEWISE_LINEAR_INTERP_CORE_MACROS_SVH
`define LUT_PIECEWISE_LINEAR_INTERP_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lpi_pkg.sv =====
// Types, codes and constants for the piecewise-linear interpolation core.
// No dependencies.
package lpi_pkg;

  localparam int WORD_BITS = 16;
  localparam int IDX_W     = 8;
  localparam int CFG_N_W   = 9;
  localparam int PROD_W    = 2 * WORD_BITS;
  localparam int SUM_W     = PROD_W + 2;
  localparam int RES_W     = 18;
  localparam int STAT_W    = 2;
  localparam int RES_MAX   = 131071;
  localparam int RES_MIN   = -131072;
  localparam int N_MIN     = 4;
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int N_RESET   = 256;

  // register map, selected by paddr[2]
  localparam logic REG_ENTRIES = 1'b0;
  localparam logic REG_DESC    = 1'b1;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_INV = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_BEFORE_HEAD = 2'd1,
    STAT_SATURATED   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic wr_en;     // write request accepted
    logic start;     // lookup request accepted
    logic scan;
    logic seg_cap;
    logic err_set;
    logic mul_load;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_vld;
    logic scan_stop;
    logic scan_first;
    logic scan_last;
    logic seg_equal;
    logic div_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/lpi_ctrl.sv =====
// Sequencer of the interpolation core: search, multiply, divide, deliver.
// Depends on lpi_pkg and the assertion macro header.
`include "lut_piecewise_linear_interp_core_macros.svh"

module lpi_ctrl
  import lpi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     req_type,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && req_type == REQ_LOOKUP) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_vld) begin
          if (stat.scan_stop && stat.scan_first) begin
            state_nxt = S_FIN;
          end else if (stat.scan_stop || stat.scan_last) begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        state_nxt = stat.seg_equal ? S_FIN : S_DIV;
      end
      S_DIV: begin
        if (stat.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.wr_en   = in_tvalid && req_type == REQ_WRITE;
        cmd.start   = in_tvalid && req_type == REQ_LOOKUP;
      end
      S_SCAN: begin
        cmd.scan    = 1'b1;
        cmd.err_set = stat.scan_vld && stat.scan_stop && stat.scan_first;
        cmd.seg_cap = stat.scan_vld && !stat.scan_first &&
                      (stat.scan_stop || stat.scan_last);
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_FIN: begin
        cmd.out_load = stat.out_free;
      end
      default: ;
    endcase
  end

  `LPI_ASSERT_IMP(a_load_free, cmd.out_load, stat.out_free, "result loaded into a full slot")
  `LPI_ASSERT_IMP(a_cap_excl, cmd.seg_cap, !cmd.err_set, "segment capture on an error")
  `LPI_ASSERT_NXT(a_start_scan, cmd.start, state_r == S_SCAN, "lookup did not enter search")
  `LPI_ASSERT_NXT(a_div_exit, state_r == S_DIV, state_r == S_DIV || state_r == S_FIN, "divide left early")

endmodule

// ===== sv/lpi_datapath.sv =====
// Table memories, search compare, segment registers, multiplier,
// restoring divider and result register. Depends on lpi_pkg.
module lpi_datapath
  import lpi_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic [CFG_N_W-1:0]   cfg_entries,
  input  logic                 cfg_desc,
  input  logic [IDX_W-1:0]     entry_index,
  input  logic [WORD_BITS-1:0] entry_key,
  input  logic [WORD_BITS-1:0] entry_value,
  input  logic [WORD_BITS-1:0] query_word,
  input  logic                 lookup_direction,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [RES_W-1:0]     result_word,
  output logic [STAT_W-1:0]    result_status
);

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > CFG_N_W) ? CNT_W : CFG_N_W;
  localparam int DCNT_W = $clog2(PROD_W);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(RES_MAX);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(RES_MIN);

  logic [WORD_BITS-1:0] key_mem [TABLE_DEPTH];
  logic [WORD_BITS-1:0] val_mem [TABLE_DEPTH];

  logic [WORD_BITS-1:0] rd_key_r, rd_val_r;
  logic                 rd_vld_r;
  logic [CNT_W-1:0]     iss_cnt_r, chk_idx_r, n_r;
  logic [WORD_BITS-1:0] q_r;
  logic                 dir_r, err_r;
  logic [WORD_BITS-1:0] px_r, py_r, x1_r, y1_r, x2_r, y2_r;
  logic [WORD_BITS-1:0] rem_r, dvs_r;
  logic [PROD_W-1:0]    quo_r;
  logic                 neg_r;
  logic [DCNT_W-1:0]    dcnt_r;
  logic                 out_vld_r;
  logic [RES_W-1:0]     res_r;
  logic [STAT_W-1:0]    rstat_r;

  logic                 wr_ok, rd_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [CMP_W-1:0]     cfg_n_ext, n_clamp;
  logic [WORD_BITS-1:0] col_cur, ans_cur;
  logic signed [WORD_BITS:0] dy, dq, dx;
  logic [WORD_BITS:0]   dy_mag, dq_mag, dx_mag;
  logic [WORD_BITS:0]   div_sh;
  logic                 div_ge;
  logic signed [SUM_W-1:0] y1_ext, quo_ext, sum;
  logic [RES_W-1:0]     fin_res;
  logic [STAT_W-1:0]    fin_stat;

  // table writes and search reads never share a cycle
  assign wr_ok   = cmd.wr_en && (32'(entry_index) < 32'(TABLE_DEPTH));
  assign wr_addr = ADDR_W'(entry_index);
  assign rd_en   = cmd.scan && (iss_cnt_r < n_r);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      key_mem[wr_addr] <= entry_key;
      val_mem[wr_addr] <= entry_value;
    end
    if (rd_en) begin
      rd_key_r <= key_mem[iss_cnt_r[ADDR_W-1:0]];
      rd_val_r <= val_mem[iss_cnt_r[ADDR_W-1:0]];
    end
  end

  // entries in use, clamped to 4..TABLE_DEPTH
  assign cfg_n_ext = CMP_W'(cfg_entries);
  always_comb begin
    if (cfg_n_ext < CMP_W'(N_MIN)) begin
      n_clamp = CMP_W'(N_MIN);
    end else if (cfg_n_ext > CMP_W'(TABLE_DEPTH)) begin
      n_clamp = CMP_W'(TABLE_DEPTH);
    end else begin
      n_clamp = cfg_n_ext;
    end
  end

  assign col_cur = (dir_r == DIR_INV) ? rd_val_r : rd_key_r;
  assign ans_cur = (dir_r == DIR_INV) ? rd_key_r : rd_val_r;

  assign stat.scan_vld   = rd_vld_r;
  assign stat.scan_stop  = cfg_desc ? (col_cur < q_r) : (col_cur > q_r);
  assign stat.scan_first = (chk_idx_r == '0);
  assign stat.scan_last  = (chk_idx_r == n_r - CNT_W'(1));
  assign stat.seg_equal  = (x1_r == x2_r);
  assign stat.div_last   = (dcnt_r == DCNT_W'(PROD_W - 1));
  assign stat.out_free   = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      iss_cnt_r <= '0;
      err_r     <= 1'b0;
      dcnt_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      if (cmd.start) begin
        iss_cnt_r <= '0;
      end else if (rd_en) begin
        iss_cnt_r <= iss_cnt_r + CNT_W'(1);
      end
      if (cmd.start) begin
        err_r <= 1'b0;
      end else if (cmd.err_set) begin
        err_r <= 1'b1;
      end
      if (cmd.mul_load) begin
        dcnt_r <= '0;
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r + DCNT_W'(1);
      end
      if (cmd.out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // segment ends as signed differences; magnitudes fit in WORD_BITS
  always_comb begin
    dy     = $signed({1'b0, y2_r}) - $signed({1'b0, y1_r});
    dq     = $signed({1'b0, q_r}) - $signed({1'b0, x1_r});
    dx     = $signed({1'b0, x2_r}) - $signed({1'b0, x1_r});
    dy_mag = dy[WORD_BITS] ? -dy : dy;
    dq_mag = dq[WORD_BITS] ? -dq : dq;
    dx_mag = dx[WORD_BITS] ? -dx : dx;
  end

  assign div_sh = {rem_r, quo_r[PROD_W-1]};
  assign div_ge = (div_sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    chk_idx_r <= iss_cnt_r;
    if (cmd.start) begin
      q_r   <= query_word;
      dir_r <= lookup_direction;
      n_r   <= n_clamp[CNT_W-1:0];
    end
    if (rd_vld_r) begin
      px_r <= col_cur;
      py_r <= ans_cur;
    end
    if (cmd.seg_cap) begin
      x1_r <= px_r;
      y1_r <= py_r;
      x2_r <= col_cur;
      y2_r <= ans_cur;
    end
    if (cmd.mul_load) begin
      quo_r <= PROD_W'(dy_mag[WORD_BITS-1:0]) * PROD_W'(dq_mag[WORD_BITS-1:0]);
      dvs_r <= dx_mag[WORD_BITS-1:0];
      rem_r <= '0;
      neg_r <= dy[WORD_BITS] ^ dq[WORD_BITS] ^ dx[WORD_BITS];
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? WORD_BITS'(div_sh - {1'b0, dvs_r}) : div_sh[WORD_BITS-1:0];
      quo_r <= {quo_r[PROD_W-2:0], div_ge};
    end
    if (cmd.out_load) begin
      res_r   <= fin_res;
      rstat_r <= fin_stat;
    end
  end

  // final add, saturation and result status
  always_comb begin
    y1_ext  = $signed(SUM_W'(y1_r));
    quo_ext = $signed(SUM_W'(quo_r));
    if (stat.seg_equal) begin
      sum = y1_ext;
    end else if (neg_r) begin
      sum = y1_ext - quo_ext;
    end else begin
      sum = y1_ext + quo_ext;
    end
    fin_stat = STAT_OK;
    if (err_r) begin
      fin_res  = '0;
      fin_stat = STAT_BEFORE_HEAD;
    end else if (sum > SAT_HI) begin
      fin_res  = SAT_HI[RES_W-1:0];
      fin_stat = STAT_SATURATED;
    end else if (sum < SAT_LO) begin
      fin_res  = SAT_LO[RES_W-1:0];
      fin_stat = STAT_SATURATED;
    end else begin
      fin_res = sum[RES_W-1:0];
    end
  end

  assign out_tvalid    = out_vld_r;
  assign result_word   = res_r;
  assign result_status = rstat_r;

endmodule

// ===== sv/lut_piecewise_linear_interp_core.sv =====
// Top level of the piecewise-linear interpolation core: register port,
// sequencer and datapath. Depends on lpi_pkg, lpi_ctrl, lpi_datapath.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------
//  in_     | in  | tvalid/tready      | tuser: req_type; tdata: pair or query
//  out_    | out | tvalid/tready      | tuser: status; tdata: result_word
//  cfg_    | in  | psel/penable/pready| entries_in_use @0, descending_search @4
//
// A write request is stored in the table when it is accepted. A lookup runs from
// its accept through the search, which compares k entries (k at most the entries
// in use) with one table read per cycle into a read register, then a multiply
// step, the one-bit-per-step divider and the load of the result register. Equal
// segment ends skip the divider, and a query before the first entry goes straight
// to the result. The result register lets the next request in while a result
// waits; a stalled output holds the core at its final step. Reset is synchronous,
// active low; table contents are undefined until written.
module lut_piecewise_linear_interp_core
  import lpi_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] entry_index, [23:8] entry_key, [39:24] entry_value,
  // [55:40] query_word, [56] lookup_direction, [63:57] zero
  input  logic [63:0] in_tdata,
  // [0] req_type
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [17:0] result_word, [23:18] zero
  output logic [23:0] out_tdata,
  // [1:0] status
  output logic [1:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [CFG_N_W-1:0] entries_r;
  logic               desc_r;
  logic               cfg_we;
  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [RES_W-1:0]   result_word;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= CFG_N_W'(N_RESET);
      desc_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_paddr[2])
        REG_ENTRIES: entries_r <= cfg_pwdata[CFG_N_W-1:0];
        REG_DESC:    desc_r    <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_ENTRIES: cfg_prdata = 32'(entries_r);
      REG_DESC:    cfg_prdata = 32'(desc_r);
      default:     cfg_prdata = '0;
    endcase
  end

  lpi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .req_type  (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lpi_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_entries      (entries_r),
    .cfg_desc         (desc_r),
    .entry_index      (in_tdata[7:0]),
    .entry_key        (in_tdata[23:8]),
    .entry_value      (in_tdata[39:24]),
    .query_word       (in_tdata[55:40]),
    .lookup_direction (in_tdata[56]),
    .out_tready       (out_tready),
    .out_tvalid       (out_tvalid),
    .result_word      (result_word),
    .result_status    (out_tuser)
  );

  assign out_tdata = {6'b0, result_word};

endmodule

// ===== tb/lut_piecewise_linear_interp_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for lut_piecewise_linear_interp_core: directed table walk, then
// randomized table loads and lookups over several register settings, checked against
// a local interpolation predictor. Depends on lpi_pkg and the core RTL.
module lut_piecewise_linear_interp_core_tb;
  import lpi_pkg::*;

  typedef struct packed {
    logic [17:0] res;
    status_t     st;
  } interp_result_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_WR, ROW_LK} row_kind_t;

  // sel: register select (ROW_CFG) or lookup direction (ROW_LK)
  // idx: register value (ROW_CFG) or entry index (ROW_WR)
  // key_q: entry key (ROW_WR) or query word (ROW_LK)
  typedef struct packed {
    row_kind_t   kind;
    logic        sel;
    logic [8:0]  idx;
    logic [15:0] key_q;
    logic [15:0] val;
    logic        typed;
    logic [17:0] res;
    status_t     st;
  } row_t;

  localparam int N_PHASES = 10;
  localparam int PH_ENTRIES [N_PHASES] = '{4, 8, 0, 16, 3, 40, 256, 511, 12, 24};
  localparam bit PH_DESC    [N_PHASES] = '{0, 1, 0, 1, 1, 0, 0, 1, 0, 1};
  localparam int PH_LOOKUPS [N_PHASES] = '{60, 60, 50, 60, 50, 60, 20, 20, 60, 60};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lut_piecewise_linear_interp_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #6 clk = ~clk;

  // shadow of the table and registers
  logic [15:0] key_mem [TABLE_DEPTH_DEF];
  logic [15:0] val_mem [TABLE_DEPTH_DEF];
  logic [8:0]  entries_cfg = 9'(N_RESET);
  logic        desc_cfg = 1'b0;

  interp_result_t pending_results [$];
  bit steady = 0;  // no idling on either side
  int stall_left = 0;
  int errors = 0;
  int n_writes = 0, n_lookups = 0, n_settings = 0;
  int n_checked = 0, n_sat = 0, n_before = 0;

  row_t script [25];

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch: %s got %h want %h", $time, what, got, want);
    errors++;
  endtask

  function automatic logic [15:0] col_word(logic dir, int i);
    return (dir == DIR_INV) ? val_mem[i] : key_mem[i];
  endfunction

  function automatic int active_entries(int e);
    if (e < N_MIN) return N_MIN;
    if (e > TABLE_DEPTH_DEF) return TABLE_DEPTH_DEF;
    return e;
  endfunction

  function automatic interp_result_t interp_predict(logic [15:0] q, logic dir);
    int n, run, s;
    bit stop;
    longint x1, x2, y1, y2, dy, dq, dx, quot, r;
    interp_result_t o;
    n = active_entries(32'(entries_cfg));
    run = 0;
    stop = 0;
    // walk until the first entry past the query
    while (run < n && !stop) begin
      stop = desc_cfg ? (col_word(dir, run) < q) : (col_word(dir, run) > q);
      if (!stop) run++;
    end
    o.st = STAT_OK;
    if (run == 0) begin
      o.res = '0;
      o.st = STAT_BEFORE_HEAD;
      return o;
    end
    s = (run - 1 > n - 2) ? n - 2 : run - 1;
    x1 = col_word(dir, s);
    x2 = col_word(dir, s + 1);
    y1 = col_word(!dir, s);
    y2 = col_word(!dir, s + 1);
    if (x1 == x2) begin
      r = y1;
    end else begin
      dy = y2 - y1;
      dq = longint'(q) - x1;
      dx = x2 - x1;
      quot = ((dy < 0 ? -dy : dy) * (dq < 0 ? -dq : dq)) / (dx < 0 ? -dx : dx);
      r = (((dy < 0) != (dq < 0)) != (dx < 0)) ? y1 - quot : y1 + quot;
    end
    if (r > RES_MAX) begin
      r = RES_MAX;
      o.st = STAT_SATURATED;
    end else if (r < RES_MIN) begin
      r = RES_MIN;
      o.st = STAT_SATURATED;
    end
    o.res = r[17:0];
    return o;
  endfunction

  task automatic send_request(logic rtype, logic [63:0] payload, logic typed,
                              interp_result_t want);
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= rtype;
    in_tdata  <= payload;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (rtype == REQ_WRITE) begin
      key_mem[payload[7:0]] = payload[23:8];
      val_mem[payload[7:0]] = payload[39:24];
      n_writes++;
    end else begin
      pending_results.push_back(typed ? want : interp_predict(payload[55:40], payload[56]));
      n_lookups++;
    end
  endtask

  // unused fields carry random bits
  task automatic send_write(logic [7:0] idx, logic [15:0] key, logic [15:0] val);
    send_request(REQ_WRITE, {7'd0, 1'($urandom), 16'($urandom), val, key, idx}, 1'b0, '0);
  endtask

  task automatic send_lookup(logic [15:0] q, logic dir, logic typed, interp_result_t want);
    send_request(REQ_LOOKUP, {7'd0, dir, q, 16'($urandom), 16'($urandom), 8'($urandom)},
                 typed, want);
  endtask

  task automatic reg_read(logic sel, output logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {sel, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    data = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // waits for the core to go idle, writes, then reads the register back
  task automatic reg_write(logic sel, logic [31:0] data);
    logic [31:0] rd;
    logic [31:0] want;
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);  // a trailing table write may still be in flight
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (sel == REG_ENTRIES) begin
      entries_cfg = data[8:0];
      want = {23'd0, data[8:0]};
    end else begin
      desc_cfg = data[0];
      want = {31'd0, data[0]};
    end
    n_settings++;
    reg_read(sel, rd);
    if (rd !== want) report_mismatch("register readback", rd, want);
  endtask

  function automatic int seg_step(int stepmax);
    if ($urandom_range(0, 7) == 0) return 0;  // equal neighbors
    if ($urandom_range(0, 7) == 0) return 1;  // steep slope
    return $urandom_range(1, stepmax);
  endfunction

  // monotonic table over entries 0..n-1, keys follow the search order
  task automatic load_table(int n, bit falling);
    int stepmax, kc, vc, i;
    bit vfall;
    stepmax = 65535 / n;
    vfall = falling ^ ($urandom_range(0, 3) == 0);
    kc = $urandom_range(0, stepmax);
    vc = $urandom_range(0, stepmax);
    for (i = 0; i < n; i++) begin
      send_write(i[7:0], falling ? 16'(65535 - kc) : 16'(kc),
                 vfall ? 16'(65535 - vc) : 16'(vc));
      kc += seg_step(stepmax);
      vc += seg_step(stepmax);
    end
  endtask

  always @(posedge clk) begin : result_check
    interp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no lookup outstanding", 32'(out_tdata), 0);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (want.st == STAT_SATURATED) n_sat++;
        if (want.st == STAT_BEFORE_HEAD) n_before++;
        if (out_tdata[17:0] !== want.res)
          report_mismatch("result_word", 32'(out_tdata[17:0]), 32'(want.res));
        if (out_tuser !== want.st)
          report_mismatch("status", 32'(out_tuser), 32'(want.st));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    #(20_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [31:0] rd;
    int p, i, j, n, lo, hi, c0, cl;
    logic dir;
    logic [15:0] q;
    interp_result_t want;

    script = '{
      '{ROW_CFG, REG_ENTRIES, 9'd4, 16'd0,     16'd0,     1'b0, 18'd0,     STAT_OK},
      '{ROW_CFG, REG_DESC,    9'd0, 16'd0,     16'd0,     1'b0, 18'd0,     STAT_OK},
      '{ROW_WR,  1'b0,        9'd0, 16'd10,    16'd0,     1'b0, 18'd0,     STAT_OK},
      '{ROW_WR,  1'b0,        9'd1, 16'd20,    16'd65535, 1'b0, 18'd0,     STAT_OK},
      '{ROW_WR,  1'b0,        9'd2, 16'd30,    16'd100,   1'b0, 18'd0,     STAT_OK},
      '{ROW_WR,  1'b0,        9'd3, 16'd30,    16'd200,   1'b0, 18'd0,     STAT_OK},
      // query below the first key
      '{ROW_LK,  DIR_FWD,     9'd0, 16'd0,     16'd0,     1'b1, 18'd0,     STAT_BEFORE_HEAD},
      '{ROW_LK,  DIR_FWD,     9'd0, 16'd10,    16'd0,     1'b1, 18'd0,     STAT_OK},
      '{ROW_LK,  DIR_FWD,     9'd0, 16'd25,    16'd0,     1'b0, 18'd0,     STAT_OK},
      // last segment has equal ends: first value comes back
      '{ROW_LK,  DIR_FWD,     9'd0, 16'd65535, 16'd0,     1'b1, 18'd100,   STAT_OK},
      '{ROW_WR,  1'b0,        9'd3, 16'd31,    16'd65535, 1'b0, 18'd0,     STAT_OK},
      '{ROW_LK,  DIR_FWD,     9'd0, 16'd65535, 16'd0,     1'b1, 18'h1FFFF, STAT_SATURATED},
      '{ROW_WR,  1'b0,        9'd3, 16'd31,    16'd0,     1'b0, 18'd0,     STAT_OK},
      '{ROW_LK,  DIR_FWD,     9'd0, 16'd65535, 16'd0,     1'b1, 18'h20000, STAT_SATURATED},
      '{ROW_LK,  DIR_INV,     9'd0, 16'd0,     16'd0,     1'b1, 18'd10,    STAT_OK},
      '{ROW_LK,  DIR_INV,     9'd0, 16'd40000, 16'd0,     1'b0, 18'd0,     STAT_OK},
      '{ROW_CFG, REG_DESC,    9'd1, 16'd0,     16'd0,     1'b0, 18'd0,     STAT_OK},
      '{ROW_WR,  1'b0,        9'd0, 16'd60000, 16'd5,     1'b0, 18'd0,     STAT_OK},
      '{ROW_WR,  1'b0,        9'd1, 16'd40000, 16'd10,    1'b0, 18'd0,     STAT_OK},
      '{ROW_WR,  1'b0,        9'd2, 16'd20000, 16'd20,    1'b0, 18'd0,     STAT_OK},
      '{ROW_WR,  1'b0,        9'd3, 16'd0,     16'd40,    1'b0, 18'd0,     STAT_OK},
      '{ROW_LK,  DIR_FWD,     9'd0, 16'd65535, 16'd0,     1'b1, 18'd0,     STAT_BEFORE_HEAD},
      '{ROW_LK,  DIR_FWD,     9'd0, 16'd30000, 16'd0,     1'b0, 18'd0,     STAT_OK},
      '{ROW_LK,  DIR_FWD,     9'd0, 16'd0,     16'd0,     1'b0, 18'd0,     STAT_OK},
      // rising value column searched as if falling
      '{ROW_LK,  DIR_INV,     9'd0, 16'd3,     16'd0,     1'b0, 18'd0,     STAT_OK}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    reg_read(REG_ENTRIES, rd);
    if (rd !== 32'(N_RESET)) report_mismatch("entries_in_use after reset", rd, N_RESET);
    reg_read(REG_DESC, rd);
    if (rd !== 32'd0) report_mismatch("descending_search after reset", rd, 0);

    foreach (script[r]) begin
      case (script[r].kind)
        ROW_CFG: reg_write(script[r].sel, 32'(script[r].idx));
        ROW_WR:  send_write(script[r].idx[7:0], script[r].key_q, script[r].val);
        default: begin
          want.res = script[r].res;
          want.st  = script[r].st;
          send_lookup(script[r].key_q, script[r].sel, script[r].typed, want);
        end
      endcase
    end

    for (p = 0; p < N_PHASES; p++) begin
      reg_write(REG_ENTRIES, PH_ENTRIES[p]);
      reg_write(REG_DESC, 32'(PH_DESC[p]));
      steady = (p == N_PHASES - 1);
      n = active_entries(PH_ENTRIES[p]);
      load_table(n, PH_DESC[p]);
      for (i = 0; i < PH_LOOKUPS[p]; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray write, may break the ordering of the active entries
          send_write(8'($urandom), 16'($urandom), 16'($urandom));
        end else begin
          dir = 1'($urandom);
          j = $urandom_range(0, n - 2);
          lo = col_word(dir, j);
          hi = col_word(dir, j + 1);
          if (lo > hi) begin
            c0 = lo;
            lo = hi;
            hi = c0;
          end
          c0 = col_word(dir, 0);
          cl = col_word(dir, n - 1);
          case ($urandom_range(0, 9))
            0: q = 16'($urandom);
            1: q = col_word(dir, j);
            2: begin
              if (desc_cfg) q = (c0 == 65535) ? 16'hFFFF : 16'($urandom_range(c0 + 1, 65535));
              else q = (c0 == 0) ? 16'h0000 : 16'($urandom_range(0, c0 - 1));
            end
            3: q = desc_cfg ? 16'($urandom_range(0, cl)) : 16'($urandom_range(cl, 65535));
            default: q = 16'($urandom_range(lo, hi));
          endcase
          send_lookup(q, dir, 1'b0, '0);
        end
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("covered %0d requests (%0d table writes, %0d lookups) over %0d register writes",
             n_writes + n_lookups, n_writes, n_lookups, n_settings);
    $display("%0d results compared: %0d saturated, %0d before the first entry, %0d errors",
             n_checked, n_sat, n_before, errors);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/lpi_pkg.sv
sv/lpi_ctrl.sv
sv/lpi_datapath.sv
sv/lut_piecewise_linear_interp_core.sv
tb/lut_piecewise_linear_interp_core_tb.sv
